// ===== design/brf_pkg.sv =====
// brf_pkg: shared types and constants for the byte ring FIFO.
// Used by every file in design/ except brf_ram; depends on nothing.
package brf_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned CapW     = 9;
  // ring never spans more than this many cells, whatever the store depth
  localparam int unsigned MaxCells = 256;

  typedef enum logic [0:0] {
    KindPut = 1'b0,
    KindGet = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [DataW-1:0]   data_in;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [DataW-1:0]   data_out;
    logic [CapW-1:0]    readable;
    logic [CapW-1:0]    writable;
  } rsp_t;

  // result fields known at accept time; data_out is finished at the top
  typedef struct packed {
    logic               valid;
    logic               ok;
    kind_e              kind;
    logic [DataW-1:0]   put_byte;
    logic [CapW-1:0]    readable;
    logic [CapW-1:0]    writable;
  } meta_t;

endpackage

// ===== design/brf_ram.sv =====
// brf_ram: generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module brf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/brf_ctrl.sv =====
// brf_ctrl: ring positions, capacity register, full/empty decisions, counts.
// Drives the store RAM ports; uses brf_pkg.
module brf_ctrl #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned RamDepth = (DEPTH < brf_pkg::MaxCells) ? DEPTH : brf_pkg::MaxCells,
  localparam int unsigned AddrW = $clog2(RamDepth)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  brf_pkg::req_t                req_i,
  input  logic                         cfg_we_i,
  input  logic [brf_pkg::CapW-1:0]     cfg_wdata_i,
  output logic                         ram_we_o,
  output logic [AddrW-1:0]             ram_waddr_o,
  output logic [brf_pkg::DataW-1:0]    ram_wdata_o,
  output logic                         ram_re_o,
  output logic [AddrW-1:0]             ram_raddr_o,
  output brf_pkg::meta_t               meta_o
);

  localparam logic [brf_pkg::CapW-1:0] CapMax = brf_pkg::CapW'(RamDepth);

  logic [brf_pkg::CapW-1:0] cap_q, cap_d;
  logic [brf_pkg::CapW-1:0] wp_q, wp_d;
  logic [brf_pkg::CapW-1:0] rp_q, rp_d;
  logic [brf_pkg::CapW-1:0] cap_new;
  logic [brf_pkg::CapW-1:0] readable, writable;
  logic                     ok;
  brf_pkg::meta_t           meta_q, meta_d;

  // capacity write saturates to 1..CapMax
  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_new = brf_pkg::CapW'(1);
    end else if (cfg_wdata_i > CapMax) begin
      cap_new = CapMax;
    end else begin
      cap_new = cfg_wdata_i;
    end
  end

  // position update
  always_comb begin
    logic [brf_pkg::CapW-1:0] other;
    logic [brf_pkg::CapW-1:0] moved;
    wp_d  = wp_q;
    rp_d  = rp_q;
    cap_d = cap_q;
    ok    = 1'b0;
    other = '0;
    moved = '0;
    if (cfg_we_i) begin
      cap_d = cap_new;
      wp_d  = '0;
      rp_d  = cap_new;
    end else if (start_i) begin
      if (req_i.kind == brf_pkg::KindPut) begin
        if (wp_q != cap_q) begin
          ok    = 1'b1;
          other = (rp_q == cap_q) ? wp_q : rp_q;
          moved = wp_q + brf_pkg::CapW'(1);
          if (moved == cap_q && other != '0) begin
            moved = '0;
          end
          if (moved == other) begin
            moved = cap_q;
          end
          wp_d = moved;
          rp_d = other;
        end
      end else begin
        if (rp_q != cap_q) begin
          ok    = 1'b1;
          other = (wp_q == cap_q) ? rp_q : wp_q;
          moved = rp_q + brf_pkg::CapW'(1);
          if (moved == cap_q && other != '0) begin
            moved = '0;
          end
          if (moved == other) begin
            moved = cap_q;
          end
          rp_d = moved;
          wp_d = other;
        end
      end
    end
  end

  // counts after the step
  always_comb begin
    if (rp_d == cap_d) begin
      readable = '0;
    end else if (wp_d == cap_d) begin
      readable = cap_d;
    end else if (rp_d < wp_d) begin
      readable = wp_d - rp_d;
    end else begin
      readable = cap_d - rp_d + wp_d;
    end
    if (wp_d == cap_d) begin
      writable = '0;
    end else if (rp_d == cap_d) begin
      writable = cap_d;
    end else if (wp_d < rp_d) begin
      writable = rp_d - wp_d;
    end else begin
      writable = cap_d - wp_d + rp_d;
    end
  end

  always_comb begin
    meta_d          = meta_q;
    meta_d.valid    = start_i && !cfg_we_i;
    if (start_i && !cfg_we_i) begin
      meta_d.ok       = ok;
      meta_d.kind     = req_i.kind;
      meta_d.put_byte = req_i.data_in;
      meta_d.readable = readable;
      meta_d.writable = writable;
    end
  end

  // positions below cap never exceed RamDepth-1, so low bits address the store
  assign ram_we_o    = ok && (req_i.kind == brf_pkg::KindPut);
  assign ram_waddr_o = wp_q[AddrW-1:0];
  assign ram_wdata_o = req_i.data_in;
  assign ram_re_o    = ok && (req_i.kind == brf_pkg::KindGet);
  assign ram_raddr_o = rp_q[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapMax;
      wp_q   <= '0;
      rp_q   <= CapMax;
      meta_q <= '0;
    end else begin
      cap_q  <= cap_d;
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      meta_q <= meta_d;
    end
  end

  assign meta_o = meta_q;

endmodule

// ===== design/byte_ring_fifo.sv =====
// byte_ring_fifo: top level of the byte ring FIFO.
// Instantiates brf_ctrl and brf_ram; uses brf_pkg.
//
// Each command (put or get one byte) taken when start_i is high and cfg_we_i
// is low yields exactly one result, strobed on done_o for a single cycle, in
// the cycle after the command edge. A new command may be issued every clock:
// the store RAM read is registered and positions live in registers updated
// at the command edge, so busy_o stays low. Results cannot be held off; the
// receiver must take each beat as it appears. Writing the capacity empties
// the ring; no clearing pass is needed since unread cells are never returned.
module byte_ring_fifo #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  brf_pkg::req_t            req_i,
  output logic                     done_o,
  output brf_pkg::rsp_t            rsp_o,
  input  logic                     cfg_we_i,
  input  logic [brf_pkg::CapW-1:0] cfg_wdata_i
);

  localparam int unsigned RamDepth =
      (DEPTH < brf_pkg::MaxCells) ? DEPTH : brf_pkg::MaxCells;
  localparam int unsigned AddrW = $clog2(RamDepth);

  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr;
  logic [brf_pkg::DataW-1:0] ram_wdata;
  logic                      ram_re;
  logic [AddrW-1:0]          ram_raddr;
  logic [brf_pkg::DataW-1:0] ram_rdata;
  brf_pkg::meta_t            meta;

  brf_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .meta_o      (meta)
  );

  brf_ram #(
    .Width (brf_pkg::DataW),
    .Depth (RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy_o = 1'b0;
  assign done_o = meta.valid;

  always_comb begin
    rsp_o.ok       = meta.ok;
    rsp_o.readable = meta.readable;
    rsp_o.writable = meta.writable;
    if (!meta.ok) begin
      rsp_o.data_out = '0;
    end else if (meta.kind == brf_pkg::KindGet) begin
      rsp_o.data_out = ram_rdata;
    end else begin
      rsp_o.data_out = meta.put_byte;
    end
  end

endmodule

// ===== design/brf_checker.sv =====
// brf_checker: port-level assertions for byte_ring_fifo, bound to the top.
// Uses brf_pkg.
module brf_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_o,
  input  brf_pkg::req_t req_i,
  input  logic          done_o,
  input  brf_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i
);

  // every accepted command answers on the next cycle
  a_cmd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !cfg_we_i |=> done_o)
    else $error("command beat without result");

  // no result appears without a command
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result beat without command");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.ok |-> rsp_o.data_out == '0)
    else $error("failed command returned data");

  // readable + writable equals capacity, which is 1..256
  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (10'(rsp_o.readable) + 10'(rsp_o.writable) != 10'd0) &&
               (10'(rsp_o.readable) + 10'(rsp_o.writable) <= 10'd256))
    else $error("readable and writable counts inconsistent");

  a_put_readable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.ok && ($past(req_i.kind) == brf_pkg::KindPut)
      |-> rsp_o.readable != '0)
    else $error("successful put left ring empty");

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .req_i    (req_i),
  .done_o   (done_o),
  .rsp_o    (rsp_o),
  .cfg_we_i (cfg_we_i)
);
